// ----- design/dnsc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the decimal number syntax checker.
// Holds character codes, parse phases, beat and state types, and the
// character class helpers. No dependencies.
package dnsc_pkg;

	// Character codes
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Parse phases
	typedef enum logic [2:0] {
		PH_LEAD       = 3'd0,
		PH_MANT       = 3'd1,
		PH_EXP_START  = 3'd2,
		PH_EXP_SIGNED = 3'd3,
		PH_EXP_DIG    = 3'd4,
		PH_TRAIL      = 3'd5
	} phase_t;

	// One input beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       end_of_text;
	} in_beat_t;

	// One result beat
	typedef struct packed {
		logic number_ok;
		logic integer_ok;
	} out_beat_t;

	// Per-string parse state
	typedef struct packed {
		phase_t phase;
		logic   mantissa_digit_seen;
		logic   point_seen;
		logic   exponent_seen;
		logic   syntax_failed;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase: PH_LEAD,
		mantissa_digit_seen: 1'b0,
		point_seen: 1'b0,
		exponent_seen: 1'b0,
		syntax_failed: 1'b0
	};

	function automatic logic is_ws(input logic [7:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == CH_MINUS) || (c == CH_PLUS);
	endfunction

endpackage

// ----- design/dnsc_char_if.sv -----
`timescale 1ns / 1ps
// Character channel: valid/ready handshake with one character beat.
// Depends on nothing.
interface dnsc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       end_of_text;

	modport source (output valid, output char_code, output has_char,
		output end_of_text, input ready);
	modport sink (input valid, input char_code, input has_char,
		input end_of_text, output ready);
endinterface

// ----- design/dnsc_result_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the two syntax flags.
// Depends on nothing.
interface dnsc_result_if;
	logic valid;
	logic ready;
	logic number_ok;
	logic integer_ok;

	modport source (output valid, output number_ok, output integer_ok, input ready);
	modport sink (input valid, input number_ok, input integer_ok, output ready);
endinterface

// ----- design/dnsc_parse_core.sv -----
`timescale 1ns / 1ps
// Parse state register and next-state logic for one character beat.
// Depends on dnsc_pkg.
module dnsc_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  dnsc_pkg::in_beat_t  beat,
	output dnsc_pkg::out_beat_t result
);
	import dnsc_pkg::*;

	parse_state_t state_q;
	parse_state_t step;
	logic [7:0]   c;

	assign c = beat.char_code;

	// Apply one character to the parse state
	always_comb begin
		step = state_q;
		if (beat.has_char && !state_q.syntax_failed) begin
			unique case (state_q.phase)
				PH_LEAD: begin
					if (is_ws(c)) begin
						step.phase = PH_LEAD;
					end else if (is_sign(c)) begin
						step.phase = PH_MANT;
					end else if (is_dig(c)) begin
						step.mantissa_digit_seen = 1'b1;
						step.phase = PH_MANT;
					end else if (c == CH_POINT) begin
						step.point_seen = 1'b1;
						step.phase = PH_MANT;
					end else begin
						step.syntax_failed = 1'b1;
					end
				end
				PH_MANT: begin
					if (is_dig(c)) begin
						step.mantissa_digit_seen = 1'b1;
					end else if (c == CH_POINT && !state_q.point_seen) begin
						step.point_seen = 1'b1;
					end else if ((c == CH_E_LO || c == CH_E_UP)
							&& state_q.mantissa_digit_seen) begin
						step.exponent_seen = 1'b1;
						step.phase = PH_EXP_START;
					end else if (is_ws(c) && state_q.mantissa_digit_seen) begin
						step.phase = PH_TRAIL;
					end else begin
						step.syntax_failed = 1'b1;
					end
				end
				PH_EXP_START: begin
					if (is_sign(c)) begin
						step.phase = PH_EXP_SIGNED;
					end else if (is_dig(c)) begin
						step.phase = PH_EXP_DIG;
					end else begin
						step.syntax_failed = 1'b1;
					end
				end
				PH_EXP_SIGNED: begin
					if (is_dig(c)) begin
						step.phase = PH_EXP_DIG;
					end else begin
						step.syntax_failed = 1'b1;
					end
				end
				PH_EXP_DIG: begin
					if (is_ws(c)) begin
						step.phase = PH_TRAIL;
					end else if (!is_dig(c)) begin
						step.syntax_failed = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (!is_ws(c)) begin
						step.syntax_failed = 1'b1;
					end
				end
				default: begin
					step.syntax_failed = 1'b1;
				end
			endcase
		end
	end

	// Judge the string as it stands after this beat
	always_comb begin
		result.number_ok = !step.syntax_failed &&
			((step.phase == PH_MANT && step.mantissa_digit_seen) ||
			 step.phase == PH_EXP_DIG || step.phase == PH_TRAIL);
		result.integer_ok = result.number_ok && !step.point_seen && !step.exponent_seen;
	end

	// Advance state; drop back to reset at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (advance) begin
			state_q <= beat.end_of_text ? PARSE_RESET : step;
		end
	end

endmodule

// ----- design/decimal_number_syntax_checker_top.sv -----
`timescale 1ns / 1ps
// Decimal number syntax checker, top level.
// Throughput: one character beat per cycle, except that an end-of-text beat waits in the
// input register while the result slot is full. A result is loaded into the result
// register when its end-of-text beat leaves the input register and is held until taken.
// Reset (arst_n low) empties both registers and returns parsing to leading whitespace.
// Depends on dnsc_pkg, dnsc_char_if, dnsc_result_if, dnsc_parse_core.
module decimal_number_syntax_checker_top (
	input  logic            clk,
	input  logic            arst_n,
	dnsc_char_if.sink       chars,
	dnsc_result_if.source   results
);
	import dnsc_pkg::*;

	logic      beat_valid_s1;
	in_beat_t  beat_s1;
	logic      res_valid_q;
	out_beat_t res_q;
	out_beat_t res_next;
	logic      res_free;
	logic      advance;

	// Move stage 1 on unless it ends a string and the result slot is full
	assign res_free     = !res_valid_q || results.ready;
	assign advance      = beat_valid_s1 && (!beat_s1.end_of_text || res_free);
	assign chars.ready  = !beat_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			beat_valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			beat_s1.char_code   <= chars.char_code;
			beat_s1.has_char    <= chars.has_char;
			beat_s1.end_of_text <= chars.end_of_text;
		end
	end

	dnsc_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.result  (res_next)
	);

	// Result register: load on a string end, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && beat_s1.end_of_text) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.end_of_text) begin
			res_q <= res_next;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.number_ok  = res_q.number_ok;
	assign results.integer_ok = res_q.integer_ok;

endmodule

// ----- bench/decimal_number_syntax_checker_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for decimal_number_syntax_checker_top: streams text strings
// one character beat at a time and checks the number/integer flags of every string.
// Depends on dnsc_pkg, dnsc_char_if, dnsc_result_if and the top level.
module decimal_number_syntax_checker_top_tb;
	import dnsc_pkg::*;

	localparam int         HALF_PERIOD   = 6;
	localparam int         RANDOM_BEATS  = 1900;
	localparam int         DRAIN_CYCLES  = 10;
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TOP        = 8'hFF;
	localparam logic [7:0] CH_LETTER_X   = 8'h78;

	logic clk;
	logic arst_n;

	dnsc_char_if   chars_bus ();
	dnsc_result_if results_bus ();

	decimal_number_syntax_checker_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.results (results_bus)
	);

	// Scanner state mirrored on the bench side
	parse_state_t scan = PARSE_RESET;
	out_beat_t    flags_due[$];
	logic [7:0]   text[$];
	int           fault_count = 0;
	int           char_beats  = 0;
	int           burst_left  = 0;

	always #HALF_PERIOD clk = ~clk;

	task automatic note_fault(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	function automatic bit blank_char(input logic [7:0] c);
		return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit sign_char(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	function automatic logic [7:0] digit_code(input int n);
		return CH_ZERO + 8'(n);
	endfunction

	// Add one character at the end of the text buffer
	function automatic void append_char(input logic [7:0] c);
		text = {text, c};
	endfunction

	// Advance the mirrored scanner by one character
	function automatic void consume_char(input logic [7:0] c);
		if (scan.syntax_failed)
			return;
		case (scan.phase)
			PH_LEAD: begin
				if (blank_char(c)) begin
				end else if (sign_char(c)) begin
					scan.phase = PH_MANT;
				end else if (digit_char(c)) begin
					scan.mantissa_digit_seen = 1'b1;
					scan.phase = PH_MANT;
				end else if (c == CH_POINT) begin
					scan.point_seen = 1'b1;
					scan.phase = PH_MANT;
				end else begin
					scan.syntax_failed = 1'b1;
				end
			end
			PH_MANT: begin
				if (digit_char(c)) begin
					scan.mantissa_digit_seen = 1'b1;
				end else if (c == CH_POINT && !scan.point_seen) begin
					scan.point_seen = 1'b1;
				end else if ((c == CH_E_LO || c == CH_E_UP) && scan.mantissa_digit_seen) begin
					scan.exponent_seen = 1'b1;
					scan.phase = PH_EXP_START;
				end else if (blank_char(c) && scan.mantissa_digit_seen) begin
					scan.phase = PH_TRAIL;
				end else begin
					scan.syntax_failed = 1'b1;
				end
			end
			PH_EXP_START: begin
				if (sign_char(c))
					scan.phase = PH_EXP_SIGNED;
				else if (digit_char(c))
					scan.phase = PH_EXP_DIG;
				else
					scan.syntax_failed = 1'b1;
			end
			PH_EXP_SIGNED: begin
				if (digit_char(c))
					scan.phase = PH_EXP_DIG;
				else
					scan.syntax_failed = 1'b1;
			end
			PH_EXP_DIG: begin
				if (blank_char(c))
					scan.phase = PH_TRAIL;
				else if (!digit_char(c))
					scan.syntax_failed = 1'b1;
			end
			PH_TRAIL: begin
				if (!blank_char(c))
					scan.syntax_failed = 1'b1;
			end
			default: scan.syntax_failed = 1'b1;
		endcase
	endfunction

	// Fold one accepted beat into the scanner; queue the flags at end of text
	function automatic void predict_flags(input in_beat_t b);
		out_beat_t r;
		if (b.has_char)
			consume_char(b.char_code);
		if (!b.end_of_text)
			return;
		r.number_ok = !scan.syntax_failed &&
			((scan.phase == PH_MANT && scan.mantissa_digit_seen) ||
			scan.phase == PH_EXP_DIG || scan.phase == PH_TRAIL);
		r.integer_ok = r.number_ok && !scan.point_seen && !scan.exponent_seen;
		flags_due = {flags_due, r};
		scan = PARSE_RESET;
	endfunction

	// Send one beat; drop valid for a random gap when the current burst runs out
	task automatic send_beat(input logic [7:0] code, input logic has, input logic last);
		in_beat_t b;
		if (burst_left == 0) begin
			chars_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
		end
		chars_bus.valid       <= 1'b1;
		chars_bus.char_code   <= code;
		chars_bus.has_char    <= has;
		chars_bus.end_of_text <= last;
		@(posedge clk);
		while (!chars_bus.ready)
			@(posedge clk);
		b.char_code   = code;
		b.has_char    = has;
		b.end_of_text = last;
		predict_flags(b);
		burst_left--;
	endtask

	// Send the buffered text; close it on its last character or with a bare end marker
	task automatic send_text(input bit bare_end, input bit with_idle_beats);
		int n;
		n = text.size();
		for (int i = 0; i < n; i++) begin
			if (with_idle_beats && $urandom_range(0, 19) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(text[i], 1'b1, (i == n - 1) && !bare_end);
			char_beats++;
		end
		if (bare_end || n == 0) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
			char_beats++;
		end
	endtask

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] pick_sign();
		return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
	endfunction

	// Fill the text buffer with a well-formed number of random shape
	function automatic void build_number();
		int  int_digits;
		int  frac_digits;
		bit  with_point;
		text = {};
		repeat ($urandom_range(0, 2)) append_char(pick_blank());
		if ($urandom_range(0, 2) == 0)
			append_char(pick_sign());
		with_point  = 1'($urandom_range(0, 1));
		int_digits  = $urandom_range(with_point ? 0 : 1, 4);
		frac_digits = $urandom_range(int_digits == 0 ? 1 : 0, 4);
		repeat (int_digits) append_char(digit_code($urandom_range(0, 9)));
		if (with_point) begin
			append_char(CH_POINT);
			repeat (frac_digits) append_char(digit_code($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 2) == 0) begin
			append_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
			if ($urandom_range(0, 1))
				append_char(pick_sign());
			repeat ($urandom_range(1, 3)) append_char(digit_code($urandom_range(0, 9)));
		end
		repeat ($urandom_range(0, 2)) append_char(pick_blank());
	endfunction

	function automatic logic [7:0] pick_tricky();
		case ($urandom_range(0, 7))
			0: return CH_POINT;
			1: return pick_sign();
			2: return CH_E_LO;
			3: return CH_E_UP;
			4: return pick_blank();
			5: return digit_code($urandom_range(0, 9));
			default: return 8'($urandom);
		endcase
	endfunction

	// Break a well-formed number: overwrite, insert or remove one character
	function automatic void corrupt_text();
		int idx;
		idx = $urandom_range(0, text.size() - 1);
		case ($urandom_range(0, 2))
			0: text[idx] = pick_tricky();
			1: text.insert(idx, pick_tricky());
			default: text.delete(idx);
		endcase
	endfunction

	// Empty text and blank-only text
	task automatic test_empty_and_blank();
		text = {};
		send_text(1'b1, 1'b0);
		text = {CH_SPACE};
		send_text(1'b0, 1'b0);
	endtask

	// Every part of the grammar in one string, then the smallest integer
	task automatic test_full_grammar();
		text = {CH_TAB, CH_PLUS, digit_code(1), CH_POINT, digit_code(5), CH_E_UP,
			CH_MINUS, CH_NINE, CH_CR};
		send_text(1'b0, 1'b0);
		text = {CH_ZERO};
		send_text(1'b0, 1'b0);
	endtask

	// Sign after the mantissa, lone point, lone sign, out-of-set bytes, sticky failure
	task automatic test_malformed();
		text = {digit_code(1), CH_MINUS};
		send_text(1'b0, 1'b0);
		text = {CH_POINT};
		send_text(1'b0, 1'b0);
		text = {CH_MINUS};
		send_text(1'b0, 1'b0);
		text = {CH_TOP};
		send_text(1'b0, 1'b0);
		text = {CH_NUL};
		send_text(1'b0, 1'b0);
		text = {CH_LETTER_X, digit_code(1)};
		send_text(1'b0, 1'b0);
	endtask

	// Beats without a character inside a string and right before its end
	task automatic test_idle_beats();
		send_beat(CH_NINE, 1'b1, 1'b0);
		send_beat(CH_E_LO, 1'b1, 1'b0);
		send_beat(CH_LETTER_X, 1'b0, 1'b0);
		send_beat(CH_PLUS, 1'b1, 1'b0);
		send_beat(CH_ZERO, 1'b1, 1'b0);
		send_beat(CH_TOP, 1'b0, 1'b1);
		char_beats += 5;
	endtask

	// Mostly well-formed numbers with random content, some of them broken
	task automatic test_random_numbers(input int beats);
		int stop_at;
		stop_at = char_beats + beats;
		while (char_beats < stop_at) begin
			if ($urandom_range(0, 49) == 0) begin
				text = {};
			end else begin
				build_number();
				if ($urandom_range(0, 9) < 3)
					corrupt_text();
			end
			send_text($urandom_range(0, 4) == 0, 1'b1);
		end
	endtask

	// Strings of arbitrary bytes
	task automatic test_random_noise(input int beats);
		int stop_at;
		stop_at = char_beats + beats;
		while (char_beats < stop_at) begin
			text = {};
			repeat ($urandom_range(0, 2)) append_char(digit_code($urandom_range(0, 9)));
			repeat ($urandom_range(1, 6)) append_char(8'($urandom));
			send_text($urandom_range(0, 4) == 0, 1'b1);
		end
	endtask

	// Receiver: switch between always ready, random stalls and a sparse ready pattern
	int stall_mode  = 0;
	int stall_left  = 0;
	int stall_phase = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= (stall_phase == 5) ? 0 : stall_phase + 1;
		case (stall_mode)
			0: results_bus.ready <= 1'b1;
			1: results_bus.ready <= 1'($urandom_range(0, 1));
			default: results_bus.ready <= (stall_phase == 0);
		endcase
	end

	// Compare each result beat with the oldest pending flags
	always @(posedge clk) begin : check_flags
		out_beat_t want;
		if (arst_n && results_bus.valid && results_bus.ready) begin
			if (flags_due.size() == 0) begin
				note_fault("result beat with no string pending");
			end else begin
				want = flags_due.pop_front();
				if (results_bus.number_ok !== want.number_ok)
					note_fault($sformatf("number_ok %b, want %b",
						results_bus.number_ok, want.number_ok));
				if (results_bus.integer_ok !== want.integer_ok)
					note_fault($sformatf("integer_ok %b, want %b",
						results_bus.integer_ok, want.integer_ok));
			end
		end
	end

	initial begin
		#2000000;
		$display("[decimal_number_syntax_checker_top] ERROR");
		$finish;
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		chars_bus.valid       = 1'b0;
		chars_bus.char_code   = CH_NUL;
		chars_bus.has_char    = 1'b0;
		chars_bus.end_of_text = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_blank();
		test_full_grammar();
		test_malformed();
		test_idle_beats();
		test_random_numbers(RANDOM_BEATS * 3 / 4);
		test_random_noise(RANDOM_BEATS / 4);

		// Drain: wait for every pending result, then idle before the final check
		chars_bus.valid <= 1'b0;
		while (flags_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("[decimal_number_syntax_checker_top] OK");
		else
			$display("[decimal_number_syntax_checker_top] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/dnsc_pkg.sv
design/dnsc_char_if.sv
design/dnsc_result_if.sv
design/dnsc_parse_core.sv
design/decimal_number_syntax_checker_top.sv
bench/decimal_number_syntax_checker_top_tb.sv
